// ===== hw/rtl/monobit_chi_square_monitor_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the monobit chi-square monitor
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MONOBIT_CHI_SQUARE_MONITOR_TOP_ASSERT_SVH
`define MONOBIT_CHI_SQUARE_MONITOR_TOP_ASSERT_SVH

// consequent checked at the same edge
`define MCSM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked at the following edge
`define MCSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mcsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsm_pkg
// Widths, register defaults, codes and helpers of the monobit chi-square monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcsm_pkg;

  localparam int unsigned RandW     = 8;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned OnesW     = 20;
  localparam int unsigned PopW      = 4;
  localparam int unsigned DevW      = 20;
  localparam int unsigned SqW       = 2 * DevW;
  localparam int unsigned SumW      = 52;
  localparam int unsigned MulAW     = 33;
  localparam int unsigned MulBW     = 20;
  localparam int unsigned ProdW     = MulAW + MulBW;
  localparam int unsigned ScaledW   = 62;
  localparam int unsigned OutTdataW = 56;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

  localparam logic [CfgW-1:0] BlockBytesRst = 16'd10000;
  localparam logic [CfgW-1:0] BlockCountRst = 16'd1000;
  localparam logic [CfgW-1:0] FailLimitRst  = 16'd3840;
  localparam logic [CfgW-1:0] WeakLimitRst  = 16'd4;

  typedef enum logic [1:0] {
    REG_BLOCK_BYTES = 2'd0,
    REG_BLOCK_COUNT = 2'd1,
    REG_FAIL_LIMIT  = 2'd2,
    REG_WEAK_LIMIT  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_OK   = 2'd0,
    VERDICT_WEAK = 2'd1,
    VERDICT_FAIL = 2'd2
  } verdict_e;

  typedef struct packed {
    logic [CfgW-1:0] block_bytes;
    logic [CfgW-1:0] block_count;
    logic [CfgW-1:0] fail_limit_milli;
    logic [CfgW-1:0] weak_limit_milli;
  } cfg_t;

  function automatic logic [PopW-1:0] popcount8(input logic [RandW-1:0] v);
    logic [PopW-1:0] n;
    n = '0;
    for (int i = 0; i < RandW; i++) begin
      n = n + PopW'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/mcsm_cfg.sv =====
// ----------------------------------------------------------------------------
// mcsm_cfg
// APB register file: block length, block count and the two verdict limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcsm_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcsm_pkg::PaddrW-1:0]       paddr,
  input  logic [mcsm_pkg::PdataW-1:0]       pwdata,
  output logic [mcsm_pkg::PdataW-1:0]       prdata,
  output logic                              pready,
  output mcsm_pkg::cfg_t                    cfg_o
);

  mcsm_pkg::cfg_t     cfg_q, cfg_d;
  mcsm_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = mcsm_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        mcsm_pkg::REG_BLOCK_BYTES: cfg_d.block_bytes      = pwdata[mcsm_pkg::CfgW-1:0];
        mcsm_pkg::REG_BLOCK_COUNT: cfg_d.block_count      = pwdata[mcsm_pkg::CfgW-1:0];
        mcsm_pkg::REG_FAIL_LIMIT:  cfg_d.fail_limit_milli = pwdata[mcsm_pkg::CfgW-1:0];
        mcsm_pkg::REG_WEAK_LIMIT:  cfg_d.weak_limit_milli = pwdata[mcsm_pkg::CfgW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mcsm_pkg::REG_BLOCK_BYTES: prdata = mcsm_pkg::PdataW'(cfg_q.block_bytes);
      mcsm_pkg::REG_BLOCK_COUNT: prdata = mcsm_pkg::PdataW'(cfg_q.block_count);
      mcsm_pkg::REG_FAIL_LIMIT:  prdata = mcsm_pkg::PdataW'(cfg_q.fail_limit_milli);
      mcsm_pkg::REG_WEAK_LIMIT:  prdata = mcsm_pkg::PdataW'(cfg_q.weak_limit_milli);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_bytes      <= mcsm_pkg::BlockBytesRst;
      cfg_q.block_count      <= mcsm_pkg::BlockCountRst;
      cfg_q.fail_limit_milli <= mcsm_pkg::FailLimitRst;
      cfg_q.weak_limit_milli <= mcsm_pkg::WeakLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/mcsm_mult.sv =====
// ----------------------------------------------------------------------------
// mcsm_mult
// Shared unsigned multiplier with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcsm_mult #(
  parameter int unsigned AW = mcsm_pkg::MulAW,
  parameter int unsigned BW = mcsm_pkg::MulBW
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  logic [AW+BW-1:0] p_q, p_d;

  assign p_d = (AW + BW)'(a_i) * (AW + BW)'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/monobit_chi_square_monitor_top.sv =====
// A byte inside a block is taken in ST_IDLE and s_axis_tready stays high.
// A byte that ends a block passes the square and accumulate steps; one that
// ends a test goes on through base, fail, weak and emit, which sets m_axis_tvalid.
// All products go through one 33x20 registered multiplier in turn.
// Reset (rst_ni low, async) clears the counters, the sum and the output valid
// flag and restores the register defaults.
// ----------------------------------------------------------------------------
// monobit_chi_square_monitor_top
// Counts one bits per block, sums squared deviations, judges each test.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module monobit_chi_square_monitor_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mcsm_pkg::PaddrW-1:0]        paddr,
  input  logic [mcsm_pkg::PdataW-1:0]        pwdata,
  output logic [mcsm_pkg::PdataW-1:0]        prdata,
  output logic                               pready,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [mcsm_pkg::RandW-1:0]         s_axis_tdata,  // [7:0] random_byte
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [51:0] deviation_square_sum, [53:52] verdict, [55:54] zero
  output logic [mcsm_pkg::OutTdataW-1:0]     m_axis_tdata
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SQUARE = 7'b0000010,
    ST_ACCUM  = 7'b0000100,
    ST_BASE   = 7'b0001000,
    ST_FAIL   = 7'b0010000,
    ST_WEAK   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } seq_state_e;

  localparam int unsigned CfgW    = mcsm_pkg::CfgW;
  localparam int unsigned OnesW   = mcsm_pkg::OnesW;
  localparam int unsigned DevW    = mcsm_pkg::DevW;
  localparam int unsigned SumW    = mcsm_pkg::SumW;
  localparam int unsigned SqW     = mcsm_pkg::SqW;
  localparam int unsigned MulAW   = mcsm_pkg::MulAW;
  localparam int unsigned MulBW   = mcsm_pkg::MulBW;
  localparam int unsigned ProdW   = mcsm_pkg::ProdW;
  localparam int unsigned ScaledW = mcsm_pkg::ScaledW;

  mcsm_pkg::cfg_t cfg;

  seq_state_e          state_q, state_d;
  logic [OnesW-1:0]    ones_q, ones_d;
  logic [CfgW-1:0]     bytes_q, bytes_d;
  logic [CfgW-1:0]     blocks_q, blocks_d;
  logic [SumW-1:0]     sum_q, sum_d;
  logic                out_valid_q, out_valid_d;

  logic [ScaledW-1:0]  scaled_q;
  logic [MulAW-1:0]    thr_q;
  logic                fail_hit_q;
  logic [mcsm_pkg::OutTdataW-1:0] out_data_q;

  logic [CfgW-1:0]     nb_eff, nc_eff, bytes_inc, blocks_inc;
  logic                in_acc, blk_end, tst_end, emit_go;
  logic [OnesW-1:0]    expected;
  logic [DevW-1:0]     dev;
  logic [SumW:0]       sum_add;
  logic [SumW-1:0]     sum_sat;
  logic [ScaledW-1:0]  prod_ext;
  mcsm_pkg::verdict_e  verdict;

  logic                mul_en;
  logic [MulAW-1:0]    mul_a;
  logic [MulBW-1:0]    mul_b;
  logic [ProdW-1:0]    prod_q;

  mcsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcsm_mult #(
    .AW (MulAW),
    .BW (MulBW)
  ) u_mult (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod_q)
  );

  // zero length or count behaves as one
  assign nb_eff = (cfg.block_bytes == '0) ? CfgW'(1) : cfg.block_bytes;
  assign nc_eff = (cfg.block_count == '0) ? CfgW'(1) : cfg.block_count;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign bytes_inc  = bytes_q + CfgW'(1);
  assign blocks_inc = blocks_q + CfgW'(1);
  assign blk_end    = (bytes_inc == '0) || (bytes_inc >= nb_eff);
  assign tst_end    = (blocks_inc == '0) || (blocks_inc >= nc_eff);

  assign expected = OnesW'({nb_eff, 2'b00});
  assign dev      = (ones_q >= expected) ? ones_q - expected : expected - ones_q;

  assign sum_add = {1'b0, sum_q} + (SumW + 1)'(prod_q[SqW-1:0]);
  assign sum_sat = sum_add[SumW] ? mcsm_pkg::SumMax : sum_add[SumW-1:0];

  assign prod_ext = ScaledW'(prod_q);
  assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

  always_comb begin
    if (fail_hit_q) begin
      verdict = mcsm_pkg::VERDICT_FAIL;
    end else if (scaled_q < prod_ext) begin
      verdict = mcsm_pkg::VERDICT_WEAK;
    end else begin
      verdict = mcsm_pkg::VERDICT_OK;
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    case (state_q)
      ST_SQUARE: begin
        mul_a = MulAW'(dev);
        mul_b = MulBW'(dev);
      end
      ST_BASE: begin
        mul_a = MulAW'(nb_eff);
        mul_b = MulBW'(nc_eff);
      end
      ST_FAIL: begin
        mul_a = {prod_q[MulAW-2:0], 1'b0};
        mul_b = MulBW'(cfg.fail_limit_milli);
      end
      ST_WEAK: begin
        mul_a = thr_q;
        mul_b = MulBW'(cfg.weak_limit_milli);
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    ones_d      = ones_q;
    bytes_d     = bytes_q;
    blocks_d    = blocks_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q;
    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          ones_d  = ones_q + OnesW'(mcsm_pkg::popcount8(s_axis_tdata));
          bytes_d = bytes_inc;
          if (blk_end) begin
            state_d = ST_SQUARE;
          end
        end
      end
      ST_SQUARE: state_d = ST_ACCUM;
      ST_ACCUM: begin
        sum_d    = sum_sat;
        ones_d   = '0;
        bytes_d  = '0;
        blocks_d = blocks_inc;
        state_d  = tst_end ? ST_BASE : ST_IDLE;
      end
      ST_BASE: state_d = ST_FAIL;
      ST_FAIL: state_d = ST_WEAK;
      ST_WEAK: state_d = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          sum_d       = '0;
          blocks_d    = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ones_q      <= '0;
      bytes_q     <= '0;
      blocks_q    <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ones_q      <= ones_d;
      bytes_q     <= bytes_d;
      blocks_q    <= blocks_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // 1000*S built as 1024*S - 32*S + 8*S over two steps
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_BASE: begin
        scaled_q <= {sum_q, 10'b0} - ScaledW'({sum_q, 5'b0});
      end
      ST_FAIL: begin
        scaled_q <= scaled_q + ScaledW'({sum_q, 3'b0});
        thr_q    <= {prod_q[MulAW-2:0], 1'b0};
      end
      ST_WEAK: begin
        fail_hit_q <= (scaled_q > prod_ext);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_data_q <= mcsm_pkg::OutTdataW'({verdict, sum_q});
        end
      end
      default: begin
        thr_q <= thr_q;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== hw/rtl/mcsm_checker.sv =====
// ----------------------------------------------------------------------------
// mcsm_checker
// Port-level checks of the monobit chi-square monitor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "monobit_chi_square_monitor_top_assert.svh"

module mcsm_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [mcsm_pkg::OutTdataW-1:0] m_axis_tdata
);

  localparam int unsigned SumW = mcsm_pkg::SumW;

  `MCSM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // a fresh result leaves the sequencer back at the input
  `MCSM_ASSERT_SAME(a_ready_after_result, $rose(m_axis_tvalid), s_axis_tready, "not ready after result")

  `MCSM_ASSERT_SAME(a_zero_not_fail, m_axis_tvalid && (m_axis_tdata[SumW-1:0] == '0), m_axis_tdata[SumW+1:SumW] != mcsm_pkg::VERDICT_FAIL, "zero sum judged not acceptable")

  // a saturated sum lies above any programmable fail limit
  `MCSM_ASSERT_SAME(a_sat_fails, m_axis_tvalid && (m_axis_tdata[SumW-1:0] == mcsm_pkg::SumMax), m_axis_tdata[SumW+1:SumW] == mcsm_pkg::VERDICT_FAIL, "saturated sum not judged failing")

endmodule

bind monobit_chi_square_monitor_top mcsm_checker u_mcsm_checker (.*);

// ===== verif/monobit_chi_square_monitor_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// monobit_chi_square_monitor_top_tb
// Drives random bytes into the monitor and checks every test report against
// a cycle-free predictor of the one-count deviation sum and the verdict.
// Register settings change between idle points, across four phases of input gaps and output stalls.
// ----------------------------------------------------------------------------

module monobit_chi_square_monitor_top_tb;
  import mcsm_pkg::*;

  localparam int unsigned    CycleLimit = 1_000_000;
  localparam int unsigned    MaxShown   = 10;
  localparam longint unsigned SumCap    = (64'd1 << SumW) - 64'd1;

  typedef struct packed {
    logic [SumW-1:0] dev_sq_sum;
    verdict_e        verdict;
  } test_report_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [PaddrW-1:0]    paddr         = '0;
  logic [PdataW-1:0]    pwdata        = '0;
  logic [PdataW-1:0]    prdata;
  logic                 pready;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [RandW-1:0]     s_axis_tdata  = '0;   // [7:0] random_byte
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;          // [51:0] sum, [53:52] verdict

  monobit_chi_square_monitor_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // register mirror and test state of the predictor
  cfg_t            cfg_mirror = {BlockBytesRst, BlockCountRst, FailLimitRst, WeakLimitRst};
  logic [19:0]     ones_cnt   = '0;
  logic [15:0]     bytes_cnt  = '0;
  logic [15:0]     blocks_cnt = '0;
  longint unsigned sum_acc    = 0;

  logic [RandW-1:0] pending_bytes[$];
  test_report_t     expected_reports[$];
  test_report_t     fresh_report;
  test_report_t     oldest_report;

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  bit          send_hold      = 1'b0;
  int unsigned mismatch_cnt   = 0;
  int unsigned reports_seen   = 0;
  int unsigned cycle_cnt      = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("[monobit_chi_square_monitor_top] ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    if (mismatch_cnt < MaxShown) begin
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
    end
    mismatch_cnt++;
  endtask

  // Advances the predictor by one byte; returns 1 when the byte closes a test.
  function automatic bit absorb_byte(input logic [RandW-1:0] b, output test_report_t rpt);
    longint unsigned nb, nc, mean, dev, base, scaled;
    nb  = (cfg_mirror.block_bytes == '0) ? 1 : cfg_mirror.block_bytes;
    nc  = (cfg_mirror.block_count == '0) ? 1 : cfg_mirror.block_count;
    rpt = '0;
    ones_cnt  = ones_cnt + 20'($countones(b));
    bytes_cnt = bytes_cnt + 16'd1;
    if (bytes_cnt != 16'd0 && bytes_cnt < nb) return 1'b0;

    mean = 4 * nb;
    dev  = (ones_cnt >= mean) ? ones_cnt - mean : mean - ones_cnt;
    if (sum_acc >= SumCap || dev * dev > SumCap - sum_acc) sum_acc = SumCap;
    else sum_acc = sum_acc + dev * dev;
    ones_cnt   = '0;
    bytes_cnt  = '0;
    blocks_cnt = blocks_cnt + 16'd1;
    if (blocks_cnt != 16'd0 && blocks_cnt < nc) return 1'b0;

    // average chi-square is sum / (2*B*C); thresholds are in thousandths
    base   = 2 * nb * nc;
    scaled = 1000 * sum_acc;
    if (scaled > cfg_mirror.fail_limit_milli * base) rpt.verdict = VERDICT_FAIL;
    else if (scaled < cfg_mirror.weak_limit_milli * base) rpt.verdict = VERDICT_WEAK;
    else rpt.verdict = VERDICT_OK;
    rpt.dev_sq_sum = sum_acc[SumW-1:0];
    sum_acc    = 0;
    blocks_cnt = '0;
    return 1'b1;
  endfunction

  // byte source: predicts each accepted item, then offers the next one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (absorb_byte(s_axis_tdata, fresh_report)) expected_reports.push_back(fresh_report);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && !send_hold &&
            $urandom_range(99) >= send_gap_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_bytes.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // report sink
  always @(posedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        reports_seen++;
        if (expected_reports.size() == 0) begin
          flag_mismatch("report with none pending", '0, m_axis_tdata);
        end else begin
          oldest_report = expected_reports.pop_front();
          if (m_axis_tdata[SumW-1:0] !== oldest_report.dev_sq_sum)
            flag_mismatch("deviation_square_sum", oldest_report.dev_sq_sum,
                          m_axis_tdata[SumW-1:0]);
          if (m_axis_tdata[SumW+1:SumW] !== oldest_report.verdict)
            flag_mismatch("verdict", oldest_report.verdict, m_axis_tdata[SumW+1:SumW]);
        end
      end
    end
  end

  // Waits until no byte is queued or offered and no report is pending, then
  // covers the block-end pipeline, which may still be busy.
  task automatic settle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_reports.size() != 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic read_check(input reg_idx_e idx);
    logic [CfgW-1:0] want;
    case (idx)
      REG_BLOCK_BYTES: want = cfg_mirror.block_bytes;
      REG_BLOCK_COUNT: want = cfg_mirror.block_count;
      REG_FAIL_LIMIT:  want = cfg_mirror.fail_limit_milli;
      default:         want = cfg_mirror.weak_limit_milli;
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(PdataW-CfgW){1'b0}}, want}) flag_mismatch("register read", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // writes a register while the block is idle, with junk in the upper bits
  task automatic set_reg(input reg_idx_e idx, input logic [CfgW-1:0] val);
    settle();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_BLOCK_BYTES: cfg_mirror.block_bytes      = val;
      REG_BLOCK_COUNT: cfg_mirror.block_count      = val;
      REG_FAIL_LIMIT:  cfg_mirror.fail_limit_milli = val;
      default:         cfg_mirror.weak_limit_milli = val;
    endcase
    read_check(idx);
  endtask

  function automatic logic [RandW-1:0] rand_byte();
    logic [RandW-1:0] b;
    case ($urandom_range(9))
      0: b = 8'h00;
      1: b = 8'hFF;
      2, 3: begin
        // balanced byte, drives the deviation toward zero
        do b = 8'($urandom); while ($countones(b) != 4);
      end
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  initial begin
    int unsigned ph_items;
    int unsigned ph_reports;
    int unsigned chunk;
    logic [CfgW-1:0] val;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < 4; r++) read_check(reg_idx_e'(r));

    // zero lengths act as one; zero limits
    set_reg(REG_BLOCK_BYTES, 16'd0);
    set_reg(REG_BLOCK_COUNT, 16'd0);
    set_reg(REG_FAIL_LIMIT, 16'd0);
    set_reg(REG_WEAK_LIMIT, 16'd0);
    @(negedge clk_i);
    pending_bytes = {8'h00, 8'hF0, 8'hFF, 8'h5A};

    // top limits
    set_reg(REG_FAIL_LIMIT, 16'hFFFF);
    set_reg(REG_WEAK_LIMIT, 16'hFFFF);
    @(negedge clk_i);
    pending_bytes = {8'h0F, 8'h01, 8'h00};
    set_reg(REG_WEAK_LIMIT, 16'd0);
    @(negedge clk_i);
    pending_bytes = {8'h00, 8'hFF};

    // block length shrunk below the bytes already taken
    set_reg(REG_BLOCK_BYTES, 16'd20);
    set_reg(REG_BLOCK_COUNT, 16'd1);
    set_reg(REG_FAIL_LIMIT, 16'd3840);
    set_reg(REG_WEAK_LIMIT, 16'd4);
    @(negedge clk_i);
    repeat (10) pending_bytes.push_back(rand_byte());
    set_reg(REG_BLOCK_BYTES, 16'd5);
    @(negedge clk_i);
    pending_bytes.push_back(8'hA5);

    // block count shrunk below the blocks already done
    set_reg(REG_BLOCK_BYTES, 16'd1);
    set_reg(REG_BLOCK_COUNT, 16'hFFFF);
    @(negedge clk_i);
    pending_bytes = {8'h12, 8'hFE, 8'h80};
    set_reg(REG_BLOCK_COUNT, 16'd2);
    @(negedge clk_i);
    pending_bytes.push_back(8'h7F);

    // long block, all ones: large deviation
    set_reg(REG_BLOCK_BYTES, 16'd128);
    set_reg(REG_BLOCK_COUNT, 16'd1);
    @(negedge clk_i);
    repeat (128) pending_bytes.push_back(8'hFF);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      case (ph)
        0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_gap_pct = 85; recv_stall_pct = 0;  end
        2: begin send_gap_pct = 0;  recv_stall_pct = 85; end
        default: begin send_gap_pct = 38; recv_stall_pct = 38; end
      endcase
      ph_items   = 0;
      ph_reports = reports_seen;
      while (ph_items < 270 || reports_seen - ph_reports < 12) begin
        // new settings land mid-block or mid-test as often as not
        for (int r = 0; r < 4; r++) begin
          if ($urandom_range(1)) begin
            case (reg_idx_e'(r))
              REG_BLOCK_BYTES, REG_BLOCK_COUNT: begin
                case ($urandom_range(19))
                  0:       val = 16'd0;
                  1:       val = 16'($urandom_range(9, 40));
                  default: val = 16'($urandom_range(1, 6));
                endcase
              end
              REG_FAIL_LIMIT: begin
                case ($urandom_range(9))
                  0:       val = 16'd0;
                  1:       val = 16'hFFFF;
                  default: val = 16'($urandom_range(0, 5000));
                endcase
              end
              default: begin
                case ($urandom_range(9))
                  0:       val = 16'd0;
                  1:       val = 16'hFFFF;
                  default: val = 16'($urandom_range(0, 2000));
                endcase
              end
            endcase
            set_reg(reg_idx_e'(r), val);
          end
        end
        chunk = $urandom_range(10, 60);
        @(negedge clk_i);
        repeat (chunk) pending_bytes.push_back(rand_byte());
        if (ph == 3 && ph_items == 0) begin
          // stop sending halfway and let every pending report drain
          while (pending_bytes.size() > chunk / 2) @(negedge clk_i);
          send_hold = 1'b1;
          while (expected_reports.size() != 0 || s_axis_tvalid) @(negedge clk_i);
          repeat (12) @(negedge clk_i);
          send_hold = 1'b0;
        end
        ph_items += chunk;
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("[monobit_chi_square_monitor_top] OK");
    end else begin
      $display("[monobit_chi_square_monitor_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/mcsm_pkg.sv
hw/rtl/mcsm_cfg.sv
hw/rtl/mcsm_mult.sv
hw/rtl/monobit_chi_square_monitor_top.sv
hw/rtl/mcsm_checker.sv
verif/monobit_chi_square_monitor_top_tb.sv
